>>> src/jrpt_pkg.sv
`default_nettype none
package jrpt_pkg;

  // field and datapath widths
  localparam int ADC_W        = 10;
  localparam int SCALE_W      = 8;
  localparam int PAN_W        = 8;
  localparam int TILT_W       = 7;
  localparam int PAN_PULSE_W  = 12;
  localparam int TILT_PULSE_W = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 10;
  localparam int DIV_NUM_W    = 17;
  localparam int QUO_W        = 7;
  localparam int BIT_IDX_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_Y = 1'b1;

  localparam logic [ADC_W-1:0] NEUTRAL_RESET = 10'd512;
  localparam logic [ADC_W-1:0] ADC_FULL      = 10'd1023;

  // quotient is at most 100, so seven bits cover it
  localparam logic [BIT_IDX_W-1:0] DIV_TOP_BIT = 3'd6;

  localparam logic [TILT_W-1:0] TILT_MAX   = 7'd90;
  localparam logic [TILT_W-1:0] TILT_RESET = 7'd45;

  localparam logic [PAN_PULSE_W-1:0]  PAN_PULSE_BASE = 12'd900;
  localparam logic [TILT_PULSE_W-1:0] TILT_A_BASE    = 11'd2000;
  localparam logic [TILT_PULSE_W-1:0] TILT_B_BASE    = 11'd1000;
  localparam logic [PAN_PULSE_W-1:0]  PAN_PULSE_MIN  = 12'd900;
  localparam logic [PAN_PULSE_W-1:0]  PAN_PULSE_MAX  = 12'd2100;
  localparam logic [PAN_PULSE_W-1:0]  TILT_PAIR_SUM  = 12'd3000;

  // controller to datapath
  typedef struct packed {
    logic                 capture;
    logic                 div_load;
    logic                 div_step;
    logic                 axis_y;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 store_scaled;
    logic                 update_angles;
    logic                 pulse_scale;
    logic                 pulse_div;
    logic                 load_out;
  } jrpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fresh;
    logic out_free;
  } jrpt_status_t;

endpackage
`default_nettype wire

>>> src/jrpt_chan_if.sv
`default_nettype none
// joystick sample channel
interface jrpt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       sample_fresh;
  logic [jrpt_pkg::ADC_W-1:0] adc_x;
  logic [jrpt_pkg::ADC_W-1:0] adc_y;

  modport source (output valid, output sample_fresh, output adc_x, output adc_y,
                  input ready);
  modport sink (input valid, input sample_fresh, input adc_x, input adc_y,
                output ready);
endinterface

// servo pulse channel
interface jrpt_out_if;
  logic                              valid;
  logic                              ready;
  logic [jrpt_pkg::PAN_PULSE_W-1:0]  pan_pulse_us;
  logic [jrpt_pkg::TILT_PULSE_W-1:0] tilt_a_pulse_us;
  logic [jrpt_pkg::TILT_PULSE_W-1:0] tilt_b_pulse_us;

  modport source (output valid, output pan_pulse_us, output tilt_a_pulse_us,
                  output tilt_b_pulse_us, input ready);
  modport sink (input valid, input pan_pulse_us, input tilt_a_pulse_us,
                input tilt_b_pulse_us, output ready);
endinterface
`default_nettype wire

>>> src/joystick_rate_pan_tilt_servo.sv
// A fresh tick passes through the x and y divisions, then the step, scale and divide states;
// a stale tick skips the divisions. A result waits in FINISH until the output register is free.
// A new tick is taken only once the previous one is through, as the block has one shared
// 7-step restoring divider, used for x then y.
// Reset (rst, synchronous): neutrals 512, scaled values 0, pan 0, tilt 45 degrees.
`default_nettype none
module joystick_rate_pan_tilt_servo (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [jrpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jrpt_pkg::CFG_DATA_W-1:0] cfg_data,
  jrpt_in_if.sink                              joy,
  jrpt_out_if.source                           servo
);

  jrpt_pkg::jrpt_cmd_t    cmd;
  jrpt_pkg::jrpt_status_t status;

  jrpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (joy.valid),
    .in_ready (joy.ready),
    .status   (status),
    .cmd      (cmd)
  );

  jrpt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_fresh    (joy.sample_fresh),
    .adc_x           (joy.adc_x),
    .adc_y           (joy.adc_y),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (servo.valid),
    .out_ready       (servo.ready),
    .pan_pulse_us    (servo.pan_pulse_us),
    .tilt_a_pulse_us (servo.tilt_a_pulse_us),
    .tilt_b_pulse_us (servo.tilt_b_pulse_us)
  );

`ifndef SYNTHESIS
  // one tick in flight at a time
  a_single_tick: assert property (@(posedge clk) disable iff (rst)
    (joy.valid && joy.ready) |=> !joy.ready)
    else $error("input taken while a tick is in flight");

  // tilt pulses mirror each other
  a_tilt_pair: assert property (@(posedge clk) disable iff (rst)
    servo.valid |-> (12'(servo.tilt_a_pulse_us) + 12'(servo.tilt_b_pulse_us)
                     == jrpt_pkg::TILT_PAIR_SUM))
    else $error("tilt pulses out of step");

  // pan pulse stays in servo range
  a_pan_range: assert property (@(posedge clk) disable iff (rst)
    servo.valid |-> (servo.pan_pulse_us >= jrpt_pkg::PAN_PULSE_MIN &&
                     servo.pan_pulse_us <= jrpt_pkg::PAN_PULSE_MAX))
    else $error("pan pulse out of range");
`endif

endmodule
`default_nettype wire

>>> src/jrpt_datapath.sv
`default_nettype none
module jrpt_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [jrpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [jrpt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 sample_fresh,
  input  wire logic [jrpt_pkg::ADC_W-1:0]           adc_x,
  input  wire logic [jrpt_pkg::ADC_W-1:0]           adc_y,
  input  wire jrpt_pkg::jrpt_cmd_t                  cmd,
  output jrpt_pkg::jrpt_status_t                    status,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [jrpt_pkg::PAN_PULSE_W-1:0]          pan_pulse_us,
  output logic [jrpt_pkg::TILT_PULSE_W-1:0]         tilt_a_pulse_us,
  output logic [jrpt_pkg::TILT_PULSE_W-1:0]         tilt_b_pulse_us
);

  logic [jrpt_pkg::ADC_W-1:0]          neutral_x;
  logic [jrpt_pkg::ADC_W-1:0]          neutral_y;
  logic                                fresh;
  logic [jrpt_pkg::ADC_W-1:0]          adc_x_hold;
  logic [jrpt_pkg::ADC_W-1:0]          adc_y_hold;
  logic [jrpt_pkg::DIV_NUM_W-1:0]      rem;
  logic [jrpt_pkg::ADC_W-1:0]          den;
  logic [jrpt_pkg::QUO_W-1:0]          quo;
  logic                                div_neg;
  logic                                div_zero;
  logic signed [jrpt_pkg::SCALE_W-1:0] scaled_x;
  logic signed [jrpt_pkg::SCALE_W-1:0] scaled_y;
  logic signed [jrpt_pkg::PAN_W-1:0]   pan_angle;
  logic [jrpt_pkg::TILT_W-1:0]         tilt_angle;
  logic [11:0]                         pan_num;
  logic [13:0]                         tilt_num;
  logic [10:0]                         pan_quo;
  logic [9:0]                          tilt_quo;

  logic [jrpt_pkg::ADC_W-1:0]          raw;
  logic [jrpt_pkg::ADC_W-1:0]          neu;
  logic                                pos;
  logic [jrpt_pkg::ADC_W-1:0]          mag;
  logic [jrpt_pkg::DIV_NUM_W-1:0]      num_load;
  logic [jrpt_pkg::ADC_W-1:0]          den_load;
  logic [jrpt_pkg::DIV_NUM_W-1:0]      den_shift;
  logic                                fits;
  logic signed [jrpt_pkg::SCALE_W-1:0] quo_signed;
  logic signed [5:0]                   step_x;
  logic signed [5:0]                   step_y;
  logic signed [8:0]                   pan_sum;
  logic signed [8:0]                   tilt_sum;
  logic signed [jrpt_pkg::PAN_W-1:0]   pan_next;
  logic [jrpt_pkg::TILT_W-1:0]         tilt_next;
  logic [7:0]                          pan_off;
  logic [27:0]                         pan_prod;
  logic [25:0]                         tilt_prod;

  // step of -10..10 from a scaled value: floor((v + 100) / 10) - 10
  function automatic logic signed [5:0] step_of(input logic signed [7:0] v);
    logic [7:0]  u;
    logic [15:0] prod;
    u    = 8'(v) + 8'd100;
    prod = 16'(u) * 16'd205;
    return $signed({1'b0, prod[15:11]}) - 6'sd10;
  endfunction

  // operand selection for the shared divider
  always_comb begin
    raw       = cmd.axis_y ? adc_y_hold : adc_x_hold;
    neu       = cmd.axis_y ? neutral_y : neutral_x;
    pos       = raw > neu;
    mag       = pos ? (raw - neu) : (neu - raw);
    num_load  = jrpt_pkg::DIV_NUM_W'(mag) * 17'd100;
    den_load  = pos ? (jrpt_pkg::ADC_FULL - neu) : neu;
    den_shift = jrpt_pkg::DIV_NUM_W'(den) << cmd.bit_idx;
    fits      = rem >= den_shift;
    if (div_zero) begin
      quo_signed = '0;
    end else if (div_neg) begin
      quo_signed = -$signed({1'b0, quo});
    end else begin
      quo_signed = $signed({1'b0, quo});
    end
  end

  // rate steps and clamped angles
  always_comb begin
    step_x   = step_of(scaled_x);
    step_y   = step_of(scaled_y);
    pan_sum  = 9'(pan_angle) + 9'(step_x);
    tilt_sum = $signed({2'b00, tilt_angle}) + 9'(step_y);
    if (pan_sum < -9'sd90) begin
      pan_next = -8'sd90;
    end else if (pan_sum > 9'sd90) begin
      pan_next = 8'sd90;
    end else begin
      pan_next = pan_sum[7:0];
    end
    if (tilt_sum < 9'sd0) begin
      tilt_next = '0;
    end else if (tilt_sum > 9'sd90) begin
      tilt_next = jrpt_pkg::TILT_MAX;
    end else begin
      tilt_next = tilt_sum[6:0];
    end
    pan_off   = 8'(pan_angle) + 8'd90;
    // divide by 3 and by 9 through reciprocal multiplies
    pan_prod  = 28'(pan_num) * 28'd43691;
    tilt_prod = 26'(tilt_num) * 26'd7282;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      neutral_x <= jrpt_pkg::NEUTRAL_RESET;
      neutral_y <= jrpt_pkg::NEUTRAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jrpt_pkg::REG_NEUTRAL_X: neutral_x <= cfg_data;
        jrpt_pkg::REG_NEUTRAL_Y: neutral_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample capture, divider and pulse scaling registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fresh      <= sample_fresh;
      adc_x_hold <= adc_x;
      adc_y_hold <= adc_y;
    end
    if (cmd.div_load) begin
      rem      <= num_load;
      den      <= den_load;
      quo      <= '0;
      div_neg  <= !pos;
      div_zero <= den_load == '0;
    end else if (cmd.div_step && fits) begin
      rem              <= rem - den_shift;
      quo[cmd.bit_idx] <= 1'b1;
    end
    if (cmd.pulse_scale) begin
      pan_num  <= 12'(pan_off) * 12'd20;
      tilt_num <= 14'(tilt_angle) * 14'd100;
    end
    if (cmd.pulse_div) begin
      pan_quo  <= pan_prod[27:17];
      tilt_quo <= tilt_prod[25:16];
    end
  end

  // held state
  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_x   <= '0;
      scaled_y   <= '0;
      pan_angle  <= '0;
      tilt_angle <= jrpt_pkg::TILT_RESET;
    end else begin
      if (cmd.store_scaled) begin
        if (cmd.axis_y) begin
          scaled_y <= quo_signed;
        end else begin
          scaled_x <= quo_signed;
        end
      end
      if (cmd.update_angles) begin
        pan_angle  <= pan_next;
        tilt_angle <= tilt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      pan_pulse_us    <= jrpt_pkg::PAN_PULSE_BASE + 12'(pan_quo);
      tilt_a_pulse_us <= jrpt_pkg::TILT_A_BASE - 11'(tilt_quo);
      tilt_b_pulse_us <= jrpt_pkg::TILT_B_BASE + 11'(tilt_quo);
    end
  end

  assign status.fresh    = fresh;
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

>>> src/jrpt_ctrl.sv
`default_nettype none
module jrpt_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire jrpt_pkg::jrpt_status_t status,
  output jrpt_pkg::jrpt_cmd_t         cmd
);

  typedef enum logic [3:0] {
    IDLE, LOAD_X, DIV_X, STORE_X, LOAD_Y, DIV_Y, STORE_Y,
    STEP, SCALE, DIVIDE, FINISH
  } state_t;

  state_t                         state;
  logic [jrpt_pkg::BIT_IDX_W-1:0] cnt;

  // sequence one tick through the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) state <= LOAD_X;
        end
        LOAD_X: begin
          cnt   <= jrpt_pkg::DIV_TOP_BIT;
          state <= status.fresh ? DIV_X : STEP;
        end
        DIV_X: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= STORE_X;
        end
        STORE_X: state <= LOAD_Y;
        LOAD_Y: begin
          cnt   <= jrpt_pkg::DIV_TOP_BIT;
          state <= DIV_Y;
        end
        DIV_Y: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= STORE_Y;
        end
        STORE_Y: state <= STEP;
        STEP:    state <= SCALE;
        SCALE:   state <= DIVIDE;
        DIVIDE:  state <= FINISH;
        FINISH: begin
          if (status.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // decode commands from state
  always_comb begin
    cmd           = '0;
    cmd.bit_idx   = cnt;
    cmd.capture   = (state == IDLE) && in_valid;
    cmd.axis_y    = (state == LOAD_Y) || (state == DIV_Y) || (state == STORE_Y);
    cmd.div_load  = (state == LOAD_X) || (state == LOAD_Y);
    cmd.div_step  = (state == DIV_X) || (state == DIV_Y);
    cmd.store_scaled  = (state == STORE_X) || (state == STORE_Y);
    cmd.update_angles = state == STEP;
    cmd.pulse_scale   = state == SCALE;
    cmd.pulse_div     = state == DIVIDE;
    cmd.load_out      = (state == FINISH) && status.out_free;
  end

  assign in_ready = state == IDLE;

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRESSURE_HOLD  = 300;

  typedef enum int {RECV_OPEN, RECV_RANDOM, RECV_PERIODIC} recv_mode_t;

  typedef struct packed {
    logic [jrpt_pkg::PAN_PULSE_W-1:0]  pan;
    logic [jrpt_pkg::TILT_PULSE_W-1:0] tilt_a;
    logic [jrpt_pkg::TILT_PULSE_W-1:0] tilt_b;
  } pulse_set_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [jrpt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [jrpt_pkg::CFG_DATA_W-1:0] cfg_data;

  jrpt_in_if  joy_if ();
  jrpt_out_if servo_if ();

  joystick_rate_pan_tilt_servo u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .joy       (joy_if),
    .servo     (servo_if)
  );

  // pulse widths still owed by the block, oldest first
  pulse_set_t pulse_q[$];

  // shadow copy of the head state and calibration
  logic [jrpt_pkg::ADC_W-1:0] head_neutral_x = jrpt_pkg::NEUTRAL_RESET;
  logic [jrpt_pkg::ADC_W-1:0] head_neutral_y = jrpt_pkg::NEUTRAL_RESET;
  int head_scaled_x = 0;
  int head_scaled_y = 0;
  int head_pan      = 0;
  int head_tilt     = int'(jrpt_pkg::TILT_RESET);

  int         errors      = 0;
  int         idle_cycles = 0;
  int         burst_left  = 0;
  bit         gapless     = 1'b0;
  recv_mode_t stall_mode  = RECV_OPEN;
  int         hold_seq    = 0;
  int         hold_seen   = 0;
  int         hold_left   = 0;
  int         hold_len    = 0;
  int         recv_phase  = 0;

  always #6 clk = ~clk;

  // scale one axis offset to -100..100, zero divisor gives zero
  function automatic int scale_offset(logic [jrpt_pkg::ADC_W-1:0] raw,
                                      logic [jrpt_pkg::ADC_W-1:0] neut);
    int off;
    int den;
    off = int'(raw) - int'(neut);
    if (off > 0) begin
      den = int'(jrpt_pkg::ADC_FULL) - int'(neut);
      return (den == 0) ? 0 : (off * 100) / den;
    end
    den = -int'(neut);
    return (den == 0) ? 0 : (off * -100) / den;
  endfunction

  function automatic int rate_step(int v);
    return ((v + 100) * 20) / 200 - 10;
  endfunction

  // advance the shadow head by one tick and return the pulses it should emit
  function automatic pulse_set_t advance_head(logic fresh,
                                              logic [jrpt_pkg::ADC_W-1:0] ax,
                                              logic [jrpt_pkg::ADC_W-1:0] ay);
    pulse_set_t p;
    if (fresh) begin
      head_scaled_x = scale_offset(ax, head_neutral_x);
      head_scaled_y = scale_offset(ay, head_neutral_y);
    end
    head_pan = head_pan + rate_step(head_scaled_x);
    if (head_pan < -90) head_pan = -90;
    if (head_pan > 90) head_pan = 90;
    head_tilt = head_tilt + rate_step(head_scaled_y);
    if (head_tilt < 0) head_tilt = 0;
    if (head_tilt > 90) head_tilt = 90;
    p.pan    = jrpt_pkg::PAN_PULSE_W'(((head_pan + 90) * 1200) / 180 + 900);
    p.tilt_a = jrpt_pkg::TILT_PULSE_W'(2000 - (head_tilt * 1000) / 90);
    p.tilt_b = jrpt_pkg::TILT_PULSE_W'(1000 + (head_tilt * 1000) / 90);
    return p;
  endfunction

  // mostly full range, some rails, some samples close to the neutral
  function automatic logic [jrpt_pkg::ADC_W-1:0] pick_adc(
      logic [jrpt_pkg::ADC_W-1:0] neut);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 1023;
      2, 3: v = int'($urandom_range(0, 40)) - 20 + int'(neut);
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return jrpt_pkg::ADC_W'(v);
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
  endtask

  // offer one tick, with bursts and gaps unless gapless, and hold until transfer
  task automatic send_tick(logic fresh, logic [jrpt_pkg::ADC_W-1:0] ax,
                           logic [jrpt_pkg::ADC_W-1:0] ay);
    int gap;
    if (!gapless && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        joy_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    joy_if.valid        <= 1'b1;
    joy_if.sample_fresh <= fresh;
    joy_if.adc_x        <= ax;
    joy_if.adc_y        <= ay;
    do @(posedge clk); while (!joy_if.ready);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic wait_drained();
    joy_if.valid <= 1'b0;
    @(posedge clk);
    while (pulse_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_neutral(logic [jrpt_pkg::CFG_IDX_W-1:0] idx,
                               logic [jrpt_pkg::ADC_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= jrpt_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == jrpt_pkg::REG_NEUTRAL_X) head_neutral_x = val;
    else head_neutral_y = val;
  endtask

  // stale ticks right after reset keep the head parked
  task automatic test_stale_hold();
    repeat (2) send_tick(1'b0, jrpt_pkg::ADC_W'($urandom), jrpt_pkg::ADC_W'($urandom));
  endtask

  // full deflection both ways, held by stale ticks; tilt reaches both clamps, pan only the upper
  task automatic test_full_deflection();
    send_tick(1'b1, jrpt_pkg::ADC_FULL, jrpt_pkg::ADC_FULL);
    repeat (9) send_tick(1'b0, jrpt_pkg::ADC_W'($urandom), jrpt_pkg::ADC_W'($urandom));
    send_tick(1'b1, '0, '0);
    repeat (9) send_tick(1'b0, jrpt_pkg::ADC_W'($urandom), jrpt_pkg::ADC_W'($urandom));
  endtask

  // tiny offsets: a small negative steps by one, a small positive does not
  task automatic test_step_asymmetry();
    send_tick(1'b1, 10'd506, 10'd506);
    send_tick(1'b1, 10'd518, 10'd518);
  endtask

  // neutrals at the rails so that a divisor goes to zero
  task automatic test_zero_divisor();
    write_neutral(jrpt_pkg::REG_NEUTRAL_X, '0);
    write_neutral(jrpt_pkg::REG_NEUTRAL_Y, jrpt_pkg::ADC_FULL);
    send_tick(1'b1, '0, jrpt_pkg::ADC_FULL);
    send_tick(1'b1, jrpt_pkg::ADC_FULL, '0);
  endtask

  // stall the servo side for a long stretch while ticks keep coming
  task automatic test_backpressure();
    stall_mode <= RECV_OPEN;
    gapless  = 1'b1;
    hold_len <= PRESSURE_HOLD;
    hold_seq <= hold_seq + 1;
    repeat (16) send_tick(1'b1, jrpt_pkg::ADC_W'($urandom), jrpt_pkg::ADC_W'($urandom));
    gapless = 1'b0;
  endtask

  // one calibration setting: fresh ticks followed by runs of stale ones
  task automatic test_random_phase(logic [jrpt_pkg::ADC_W-1:0] nx,
                                   logic [jrpt_pkg::ADC_W-1:0] ny,
                                   recv_mode_t mode, int count);
    int sent;
    int run;
    write_neutral(jrpt_pkg::REG_NEUTRAL_X, nx);
    write_neutral(jrpt_pkg::REG_NEUTRAL_Y, ny);
    stall_mode <= mode;
    sent = 0;
    while (sent < count) begin
      send_tick(1'b1, pick_adc(nx), pick_adc(ny));
      sent++;
      if ($urandom_range(0, 9) < 6) begin
        run = $urandom_range(1, 20);
        repeat (run) send_tick(1'b0, jrpt_pkg::ADC_W'($urandom),
                               jrpt_pkg::ADC_W'($urandom));
        sent += run;
      end
    end
  endtask

  // record the expected pulses at each tick transfer
  always @(posedge clk) begin
    if (!rst && joy_if.valid && joy_if.ready)
      pulse_q.push_back(advance_head(joy_if.sample_fresh, joy_if.adc_x, joy_if.adc_y));
  end

  // compare each pulse transfer with the oldest expectation
  always @(posedge clk) begin
    pulse_set_t want;
    if (!rst && servo_if.valid && servo_if.ready) begin
      if (pulse_q.size() == 0) begin
        report("unexpected pulse transfer", int'(servo_if.pan_pulse_us), 0);
      end else begin
        want = pulse_q.pop_front();
        if (servo_if.pan_pulse_us !== want.pan)
          report("pan_pulse_us", int'(servo_if.pan_pulse_us), int'(want.pan));
        if (servo_if.tilt_a_pulse_us !== want.tilt_a)
          report("tilt_a_pulse_us", int'(servo_if.tilt_a_pulse_us), int'(want.tilt_a));
        if (servo_if.tilt_b_pulse_us !== want.tilt_b)
          report("tilt_b_pulse_us", int'(servo_if.tilt_b_pulse_us), int'(want.tilt_b));
      end
    end
  end

  // servo side ready pattern, with a counted hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen       <= hold_seq;
      hold_left       <= hold_len;
      servo_if.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      servo_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        RECV_OPEN:   servo_if.ready <= 1'b1;
        RECV_RANDOM: servo_if.ready <= ($urandom_range(0, 9) < 7);
        default:     servo_if.ready <= ((recv_phase % 7) >= 3);
      endcase
    end
    recv_phase <= recv_phase + 1;
  end

  // end the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((joy_if.valid && joy_if.ready) || (servo_if.valid && servo_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("joystick_rate_pan_tilt_servo verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = jrpt_pkg::REG_NEUTRAL_X;
    cfg_data            = '0;
    joy_if.valid        = 1'b0;
    joy_if.sample_fresh = 1'b0;
    joy_if.adc_x        = '0;
    joy_if.adc_y        = '0;
    servo_if.ready      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_stale_hold();
    test_full_deflection();
    test_step_asymmetry();
    test_zero_divisor();
    test_backpressure();
    test_random_phase('0, jrpt_pkg::ADC_FULL, RECV_OPEN, 65);
    test_random_phase(jrpt_pkg::ADC_FULL, '0, RECV_RANDOM, 65);
    test_random_phase(jrpt_pkg::NEUTRAL_RESET, jrpt_pkg::NEUTRAL_RESET, RECV_PERIODIC, 65);
    test_random_phase(jrpt_pkg::ADC_W'($urandom), jrpt_pkg::ADC_W'($urandom),
                      RECV_RANDOM, 65);
    test_random_phase(10'd1, 10'd1022, RECV_OPEN, 65);
    test_random_phase(jrpt_pkg::ADC_W'($urandom), jrpt_pkg::ADC_W'($urandom),
                      RECV_PERIODIC, 65);

    // let the last results land, then give the block time to show extras
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pulse_q.size() == 0) begin
      $display("joystick_rate_pan_tilt_servo verification clean");
    end else begin
      $display("joystick_rate_pan_tilt_servo verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
src/jrpt_pkg.sv
src/jrpt_chan_if.sv
src/jrpt_datapath.sv
src/jrpt_ctrl.sv
src/joystick_rate_pan_tilt_servo.sv
test/testbench.sv
